// ===== sv/cst_pkg.sv =====
// Shared token types, kind codes and keyword constants for the C subset tokenizer.
package cst_pkg;

    localparam int KIND_W  = 5;
    localparam int VALUE_W = 32;
    localparam int START_W = 16;
    localparam int LEN_W   = 17;
    localparam int WIN_W   = 48;

    localparam logic [KIND_W-1:0] KIND_EOF    = 5'd0;
    localparam logic [KIND_W-1:0] KIND_NUM    = 5'd1;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd2;
    localparam logic [KIND_W-1:0] KIND_INT    = 5'd3;
    localparam logic [KIND_W-1:0] KIND_RETURN = 5'd4;
    localparam logic [KIND_W-1:0] KIND_IF     = 5'd5;
    localparam logic [KIND_W-1:0] KIND_ELSE   = 5'd6;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd7;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd8;
    localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd9;
    localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd10;
    localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd11;
    localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd12;
    localparam logic [KIND_W-1:0] KIND_EQ     = 5'd13;
    localparam logic [KIND_W-1:0] KIND_NE     = 5'd14;
    localparam logic [KIND_W-1:0] KIND_LT     = 5'd15;
    localparam logic [KIND_W-1:0] KIND_LE     = 5'd16;
    localparam logic [KIND_W-1:0] KIND_GT     = 5'd17;
    localparam logic [KIND_W-1:0] KIND_GE     = 5'd18;
    localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd19;
    localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd20;
    localparam logic [KIND_W-1:0] KIND_STAR   = 5'd21;
    localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd22;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 5'd23;

    localparam logic [WIN_W-1:0] KW_INT    = 48'h0000_0069_6E74;
    localparam logic [WIN_W-1:0] KW_RETURN = 48'h7265_7475_726E;
    localparam logic [WIN_W-1:0] KW_IF     = 48'h0000_0000_6966;
    localparam logic [WIN_W-1:0] KW_ELSE   = 48'h0000_656C_7365;

    localparam logic [LEN_W-1:0] RUN_MAX = 17'd65536;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
    } token_t;

    typedef struct packed {
        logic   two;
        token_t tok0;
        token_t tok1;
    } token_pair_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

// ===== sv/c_subset_tokenizer.sv =====
// Top level of the C subset tokenizer: lexer front end, token queue and output back end.
//
//   channel  dir  tdata                                        tuser  tlast
//   s_axis   in   ch[7:0]                                      -      -
//   m_axis   out  number_value, ident_start, ident_length     kind   last
//
// One source byte is taken per cycle while the token queue is not full; a byte that closes a
// token and emits its own gives two tokens, which leave one after the other through the output register.
// The front end halts on an error token and ignores all bytes until reset.
// Reset clears lexer state, the queue and the output register at once; no clearing pass.
// The input stalls only while the four-entry token queue is full.
module c_subset_tokenizer #(
    parameter int MAX_SOURCE_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] number_value, [47:32] ident_start,
                                        // [64:48] ident_length, [71:65] zero
    output logic [4:0]  m_axis_tuser,   // [4:0] kind
    output logic        m_axis_tlast
);
    import cst_pkg::*;

    logic          accept, push, pop;
    token_pair_t   push_pair, head;
    queue_status_t status;
    token_t        out_tok;

    assign s_axis_tready = !status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cst_front #(
        .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .ch    (s_axis_tdata),
        .push  (push),
        .pair  (push_pair)
    );

    cst_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pair(push_pair),
        .pop      (pop),
        .head     (head),
        .status   (status)
    );

    cst_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .status   (status),
        .pop      (pop),
        .out_ready(m_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_tok  (out_tok),
        .out_last (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, out_tok.length, out_tok.start, out_tok.value};
    assign m_axis_tuser = out_tok.kind;

endmodule

// ===== sv/cst_front.sv =====
// Lexer front end: accepts source bytes and classifies them into token pairs.
module cst_front #(
    parameter int MAX_SOURCE_BYTES = 65536
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           ch,
    output logic                 push,
    output cst_pkg::token_pair_t pair
);
    import cst_pkg::*;

    localparam int POS_W = $clog2(MAX_SOURCE_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SOURCE_BYTES);

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_NUM   = 3'd1;
    localparam logic [2:0] MODE_IDENT = 3'd2;
    localparam logic [2:0] MODE_OP    = 3'd3;
    localparam logic [2:0] MODE_HALT  = 3'd4;

    localparam logic [1:0] PEND_ASSIGN = 2'd0;
    localparam logic [1:0] PEND_BANG   = 2'd1;
    localparam logic [1:0] PEND_LT     = 2'd2;
    localparam logic [1:0] PEND_GT     = 2'd3;

    logic [2:0]         mode_reg,  mode_next;
    logic [1:0]         pend_reg,  pend_next;
    logic [VALUE_W-1:0] acc_reg,   acc_next;
    logic [START_W-1:0] tstart_reg, tstart_next;
    logic [LEN_W-1:0]   run_reg,   run_next;
    logic [WIN_W-1:0]   win_reg,   win_next;
    logic [POS_W-1:0]   pos_reg,   pos_next;

    logic [POS_W+START_W-1:0] pos_ext;
    logic                     is_digit, is_alpha, is_space, is_ident;
    logic [3:0]               digit;
    logic                     has_close, has_disp, dispatch, advance;
    token_t                   tok_close, tok_disp;

    assign pos_ext  = (POS_W + START_W)'(pos_reg);
    assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign is_alpha = ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
    assign is_space = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
    assign is_ident = is_alpha || is_digit || (ch == 8'h5F);
    assign digit    = 4'(ch - 8'h30);

    function automatic token_t op_token(input logic [KIND_W-1:0] k);
        token_t t;
        t        = '0;
        t.kind   = k;
        return t;
    endfunction

    always_comb
    begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        acc_next    = acc_reg;
        tstart_next = tstart_reg;
        run_next    = run_reg;
        win_next    = win_reg;
        pos_next    = pos_reg;
        has_close   = 1'b0;
        has_disp    = 1'b0;
        tok_close   = '0;
        tok_disp    = '0;
        dispatch    = 1'b0;
        advance     = 1'b0;

        if (mode_reg != MODE_HALT)
        begin
            dispatch = 1'b1;
            unique case (mode_reg)
                MODE_NUM:
                begin
                    if (is_digit)
                    begin
                        acc_next = {acc_reg[VALUE_W-4:0], 3'b000}
                                 + {acc_reg[VALUE_W-2:0], 1'b0}
                                 + VALUE_W'(digit);
                        dispatch = 1'b0;
                        advance  = 1'b1;
                    end
                    else
                    begin
                        has_close       = 1'b1;
                        tok_close.kind  = KIND_NUM;
                        tok_close.value = acc_reg;
                        mode_next       = MODE_IDLE;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_ident)
                    begin
                        if (run_reg < RUN_MAX)
                            run_next = run_reg + LEN_W'(1);
                        win_next = {win_reg[WIN_W-9:0], ch};
                        dispatch = 1'b0;
                        advance  = 1'b1;
                    end
                    else
                    begin
                        has_close = 1'b1;
                        mode_next = MODE_IDLE;
                        priority if (run_reg == LEN_W'(3) && win_reg == KW_INT)
                            tok_close = op_token(KIND_INT);
                        else if (run_reg == LEN_W'(6) && win_reg == KW_RETURN)
                            tok_close = op_token(KIND_RETURN);
                        else if (run_reg == LEN_W'(2) && win_reg == KW_IF)
                            tok_close = op_token(KIND_IF);
                        else if (run_reg == LEN_W'(4) && win_reg == KW_ELSE)
                            tok_close = op_token(KIND_ELSE);
                        else
                        begin
                            tok_close.kind   = KIND_IDENT;
                            tok_close.start  = tstart_reg;
                            tok_close.length = run_reg;
                        end
                    end
                end
                MODE_OP:
                begin
                    has_close = 1'b1;
                    mode_next = MODE_IDLE;
                    if (ch == 8'h3D)
                    begin
                        unique case (pend_reg)
                            PEND_ASSIGN: tok_close = op_token(KIND_EQ);
                            PEND_BANG:   tok_close = op_token(KIND_NE);
                            PEND_LT:     tok_close = op_token(KIND_LE);
                            PEND_GT:     tok_close = op_token(KIND_GE);
                        endcase
                        dispatch = 1'b0;
                        advance  = 1'b1;
                    end
                    else
                    begin
                        unique case (pend_reg)
                            PEND_ASSIGN: tok_close = op_token(KIND_ASSIGN);
                            PEND_BANG:   tok_close = op_token(KIND_ERROR);
                            PEND_LT:     tok_close = op_token(KIND_LT);
                            PEND_GT:     tok_close = op_token(KIND_GT);
                        endcase
                        if (pend_reg == PEND_BANG)
                        begin
                            mode_next = MODE_HALT;
                            dispatch  = 1'b0;
                        end
                    end
                end
                default: ;
            endcase

            if (dispatch)
            begin
                priority if (ch == 8'h00)
                begin
                    has_disp    = 1'b1;
                    tok_disp    = op_token(KIND_EOF);
                    mode_next   = MODE_IDLE;
                    pend_next   = PEND_ASSIGN;
                    acc_next    = '0;
                    tstart_next = '0;
                    run_next    = '0;
                    win_next    = '0;
                    pos_next    = '0;
                end
                else if (is_space)
                    advance = 1'b1;
                else if (is_digit)
                begin
                    mode_next = MODE_NUM;
                    acc_next  = VALUE_W'(digit);
                    advance   = 1'b1;
                end
                else if (is_alpha || ch == 8'h5F)
                begin
                    mode_next   = MODE_IDENT;
                    tstart_next = pos_ext[START_W-1:0];
                    run_next    = LEN_W'(1);
                    win_next    = WIN_W'(ch);
                    advance     = 1'b1;
                end
                else
                begin
                    advance = 1'b1;
                    unique case (ch)
                        8'h28: begin has_disp = 1'b1; tok_disp = op_token(KIND_LPAREN); end
                        8'h29: begin has_disp = 1'b1; tok_disp = op_token(KIND_RPAREN); end
                        8'h7B: begin has_disp = 1'b1; tok_disp = op_token(KIND_LBRACE); end
                        8'h7D: begin has_disp = 1'b1; tok_disp = op_token(KIND_RBRACE); end
                        8'h3B: begin has_disp = 1'b1; tok_disp = op_token(KIND_SEMI); end
                        8'h2B: begin has_disp = 1'b1; tok_disp = op_token(KIND_PLUS); end
                        8'h2D: begin has_disp = 1'b1; tok_disp = op_token(KIND_MINUS); end
                        8'h2A: begin has_disp = 1'b1; tok_disp = op_token(KIND_STAR); end
                        8'h2F: begin has_disp = 1'b1; tok_disp = op_token(KIND_SLASH); end
                        8'h3D: begin mode_next = MODE_OP; pend_next = PEND_ASSIGN; end
                        8'h21: begin mode_next = MODE_OP; pend_next = PEND_BANG; end
                        8'h3C: begin mode_next = MODE_OP; pend_next = PEND_LT; end
                        8'h3E: begin mode_next = MODE_OP; pend_next = PEND_GT; end
                        default:
                        begin
                            has_disp  = 1'b1;
                            tok_disp  = op_token(KIND_ERROR);
                            mode_next = MODE_HALT;
                            advance   = 1'b0;
                        end
                    endcase
                end
            end

            if (advance && pos_reg < POS_MAX)
                pos_next = pos_reg + POS_W'(1);
        end
    end

    always_comb
    begin
        push = accept && (has_close || has_disp);
        if (has_close)
        begin
            pair.two  = has_disp;
            pair.tok0 = tok_close;
            pair.tok1 = tok_disp;
        end
        else
        begin
            pair.two  = 1'b0;
            pair.tok0 = tok_disp;
            pair.tok1 = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pend_reg   <= PEND_ASSIGN;
            acc_reg    <= '0;
            tstart_reg <= '0;
            run_reg    <= '0;
            win_reg    <= '0;
            pos_reg    <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            acc_reg    <= acc_next;
            tstart_reg <= tstart_next;
            run_reg    <= run_next;
            win_reg    <= win_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

// ===== sv/cst_queue.sv =====
// Short token-pair queue between the lexer front end and the output back end.
module cst_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cst_pkg::token_pair_t   push_pair,
    input  logic                   pop,
    output cst_pkg::token_pair_t   head,
    output cst_pkg::queue_status_t status
);
    import cst_pkg::*;

    token_pair_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg,  count_next;
    logic                do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_pair;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/cst_back.sv =====
// Output back end: splits queued token pairs into single tokens in an output register.
module cst_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cst_pkg::token_pair_t   head,
    input  cst_pkg::queue_status_t status,
    output logic                   pop,
    input  logic                   out_ready,
    output logic                   out_valid,
    output cst_pkg::token_t        out_tok,
    output logic                   out_last
);
    import cst_pkg::*;

    logic   valid_reg, valid_next;
    logic   phase_reg, phase_next;
    token_t tok_reg,   tok_next;
    logic   last_reg,  last_next;
    logic   load;

    assign load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        tok_next   = tok_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load)
        begin
            priority if (phase_reg)
            begin
                valid_next = 1'b1;
                tok_next   = head.tok1;
                last_next  = 1'b1;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
            else if (!status.empty)
            begin
                valid_next = 1'b1;
                tok_next   = head.tok0;
                last_next  = !head.two;
                phase_next = head.two;
                pop        = !head.two;
            end
            else
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg  <= tok_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;
    assign out_last  = last_reg;

endmodule

// ===== sv/cst_checker.sv =====
// Port-level checks for the C subset tokenizer and their bind to the top level.
module cst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [4:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import cst_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= KIND_ERROR)
        else $error("token kind out of range");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_EOF |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("eof token not final or carries data");

    a_value_num: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_NUM |-> m_axis_tdata[31:0] == '0)
        else $error("value on non-number token");

    a_ident_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_IDENT |-> m_axis_tdata[71:32] == '0)
        else $error("identifier fields on non-identifier token");

endmodule

bind c_subset_tokenizer cst_checker u_cst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);

// ===== tb/cst_token_checker.sv =====
// Token checker: predicts the token stream from accepted source bytes and compares every output token.
module cst_token_checker #(
    parameter int MAX_SOURCE_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    input  logic [4:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          mismatches,
    output int          pending
);
    import cst_pkg::*;

    localparam logic [7:0] END_OF_SOURCE = 8'h00;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_NUM,
        SCAN_IDENT,
        SCAN_OP,
        SCAN_HALT
    } scan_mode_e;

    typedef enum logic [1:0] {
        PEND_ASSIGN,
        PEND_BANG,
        PEND_LT,
        PEND_GT
    } pend_op_e;

    typedef struct packed {
        token_t tok;
        logic   last;
    } token_beat_t;

    scan_mode_e         mode;
    pend_op_e           pend_op;
    logic [VALUE_W-1:0] num_acc;
    logic [31:0]        tok_start;
    logic [LEN_W-1:0]   run_len;
    logic [WIN_W-1:0]   kw_window;
    logic [31:0]        byte_pos;

    token_beat_t expected_tokens[$];
    int          fail_count = 0;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [KIND_W-1:0] op_kind(input pend_op_e p, input logic paired);
        case (p)
            PEND_ASSIGN: return paired ? KIND_EQ : KIND_ASSIGN;
            PEND_BANG:   return paired ? KIND_NE : KIND_ERROR;
            PEND_LT:     return paired ? KIND_LE : KIND_LT;
            default:     return paired ? KIND_GE : KIND_GT;
        endcase
    endfunction

    task automatic reset_lexer();
        mode      = SCAN_IDLE;
        pend_op   = PEND_ASSIGN;
        num_acc   = '0;
        tok_start = '0;
        run_len   = '0;
        kw_window = '0;
        byte_pos  = '0;
    endtask

    task automatic add_token(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                             input logic [31:0] start, input logic [LEN_W-1:0] length);
        token_beat_t t;
        t.tok.kind   = kind;
        t.tok.value  = value;
        t.tok.start  = start[START_W-1:0];
        t.tok.length = length;
        t.last       = 1'b0;
        expected_tokens.push_back(t);
    endtask

    task automatic close_ident();
        if (run_len == LEN_W'(3) && kw_window == KW_INT)
            add_token(KIND_INT, '0, '0, '0);
        else if (run_len == LEN_W'(6) && kw_window == KW_RETURN)
            add_token(KIND_RETURN, '0, '0, '0);
        else if (run_len == LEN_W'(2) && kw_window == KW_IF)
            add_token(KIND_IF, '0, '0, '0);
        else if (run_len == LEN_W'(4) && kw_window == KW_ELSE)
            add_token(KIND_ELSE, '0, '0, '0);
        else
            add_token(KIND_IDENT, '0, tok_start, run_len);
    endtask

    task automatic lex_byte(input logic [7:0] c);
        int          size_prior;
        logic        taken;
        logic        frozen;
        token_beat_t tail;
        size_prior = expected_tokens.size();
        taken      = 1'b0;
        frozen     = 1'b0;
        if (mode == SCAN_HALT)
            return;
        case (mode)
            SCAN_NUM:
            begin
                if (is_digit(c))
                begin
                    num_acc = num_acc * 32'd10 + 32'(c - "0");
                    taken   = 1'b1;
                end
                else
                begin
                    add_token(KIND_NUM, num_acc, '0, '0);
                    mode = SCAN_IDLE;
                end
            end
            SCAN_IDENT:
            begin
                if (is_alpha(c) || is_digit(c) || c == "_")
                begin
                    if (run_len < RUN_MAX)
                        run_len = run_len + LEN_W'(1);
                    kw_window = {kw_window[WIN_W-9:0], c};
                    taken     = 1'b1;
                end
                else
                begin
                    close_ident();
                    mode = SCAN_IDLE;
                end
            end
            SCAN_OP:
            begin
                mode = SCAN_IDLE;
                if (c == "=")
                begin
                    add_token(op_kind(pend_op, 1'b1), '0, '0, '0);
                    taken = 1'b1;
                end
                else
                begin
                    add_token(op_kind(pend_op, 1'b0), '0, '0, '0);
                    if (pend_op == PEND_BANG)
                    begin
                        mode   = SCAN_HALT;
                        frozen = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        if (!taken && !frozen)
        begin
            if (c == END_OF_SOURCE)
            begin
                add_token(KIND_EOF, '0, '0, '0);
                reset_lexer();
                frozen = 1'b1;
            end
            else if (is_space(c))
            begin
            end
            else if (is_digit(c))
            begin
                mode    = SCAN_NUM;
                num_acc = 32'(c - "0");
            end
            else if (is_alpha(c) || c == "_")
            begin
                mode      = SCAN_IDENT;
                tok_start = byte_pos;
                run_len   = LEN_W'(1);
                kw_window = WIN_W'(c);
            end
            else
            begin
                case (c)
                    "(": add_token(KIND_LPAREN, '0, '0, '0);
                    ")": add_token(KIND_RPAREN, '0, '0, '0);
                    "{": add_token(KIND_LBRACE, '0, '0, '0);
                    "}": add_token(KIND_RBRACE, '0, '0, '0);
                    ";": add_token(KIND_SEMI, '0, '0, '0);
                    "+": add_token(KIND_PLUS, '0, '0, '0);
                    "-": add_token(KIND_MINUS, '0, '0, '0);
                    "*": add_token(KIND_STAR, '0, '0, '0);
                    "/": add_token(KIND_SLASH, '0, '0, '0);
                    "=":
                    begin
                        mode    = SCAN_OP;
                        pend_op = PEND_ASSIGN;
                    end
                    "!":
                    begin
                        mode    = SCAN_OP;
                        pend_op = PEND_BANG;
                    end
                    "<":
                    begin
                        mode    = SCAN_OP;
                        pend_op = PEND_LT;
                    end
                    ">":
                    begin
                        mode    = SCAN_OP;
                        pend_op = PEND_GT;
                    end
                    default:
                    begin
                        add_token(KIND_ERROR, '0, '0, '0);
                        mode   = SCAN_HALT;
                        frozen = 1'b1;
                    end
                endcase
            end
        end

        if (!frozen && byte_pos < MAX_SOURCE_BYTES)
            byte_pos = byte_pos + 1;
        if (expected_tokens.size() > size_prior)
        begin
            tail      = expected_tokens.pop_back();
            tail.last = 1'b1;
            expected_tokens.push_back(tail);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_token();
        token_beat_t want;
        if (expected_tokens.size() == 0)
        begin
            $display("%0t: unexpected token, expected none, actual kind %0d", $time, m_axis_tuser);
            fail_count++;
            return;
        end
        want = expected_tokens.pop_front();
        check_field("kind", 32'(want.tok.kind), 32'(m_axis_tuser));
        check_field("number_value", want.tok.value, m_axis_tdata[VALUE_W-1:0]);
        check_field("ident_start", 32'(want.tok.start),
                    32'(m_axis_tdata[VALUE_W+START_W-1:VALUE_W]));
        check_field("ident_length", 32'(want.tok.length),
                    32'(m_axis_tdata[VALUE_W+START_W+LEN_W-1:VALUE_W+START_W]));
        check_field("last", 32'(want.last), 32'(m_axis_tlast));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_lexer();
            expected_tokens.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                lex_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_token();
        end
        mismatches <= fail_count;
        pending    <= expected_tokens.size();
    end

endmodule

// ===== tb/c_subset_tokenizer_tb.sv =====
// Testbench top for the C subset tokenizer: clock, reset, source byte stimulus, output stalls, verdict.
module c_subset_tokenizer_tb;
    import cst_pkg::*;

    localparam int         CLK_HALF        = 6;
    localparam int         LONG_IDENT_LEN  = 300;
    localparam int         RANDOM_BYTES    = 1050;
    localparam int         SQUEEZE_AT      = LONG_IDENT_LEN + 200;
    localparam int         HOLD_CYCLES     = 400;
    localparam int         DRAIN_CYCLES    = 16;
    localparam int         LIMIT_CYCLES    = 8_000_000;
    localparam logic [7:0] END_OF_SOURCE   = 8'h00;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [4:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int mismatches;
    int pending;
    int bytes_sent = 0;
    int burst_left = 0;

    string keywords[4]   = '{"int", "return", "if", "else"};
    string operators[16] = '{"(", ")", "{", "}", ";", "+", "-", "*", "/",
                             "=", "==", "!=", "<", "<=", ">", ">="};

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    c_subset_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    cst_token_checker token_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    function automatic logic lexer_accepts(input logic [7:0] c);
        if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
            return 1'b1;
        if (c == "_" || c == " " || (c >= 8'h09 && c <= 8'h0D) || c == END_OF_SOURCE)
            return 1'b1;
        case (c)
            "(", ")", "{", "}", ";", "+", "-", "*", "/", "=", "<", ">": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] ident_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r < 62)
            return 8'("0" + r - 52);
        return "_";
    endfunction

    function automatic logic [7:0] lead_char();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] space_char();
        return ($urandom_range(0, 1) == 1) ? 8'(" ") : 8'($urandom_range(9, 13));
    endfunction

    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        burst_left--;
        bytes_sent <= bytes_sent + 1;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_token();
        int    pick;
        int    r;
        string kw;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            push_text(keywords[$urandom_range(0, 3)]);
        else if (pick < 20)
        begin
            // near-miss keywords: one byte longer or one byte shorter
            kw = keywords[$urandom_range(0, 3)];
            if ($urandom_range(0, 1) == 1)
            begin
                push_text(kw);
                push_byte(ident_char());
            end
            else
                push_text(kw.substr(0, kw.len() - 2));
        end
        else if (pick < 40)
        begin
            push_byte(lead_char());
            repeat ($urandom_range(0, 8)) push_byte(ident_char());
        end
        else if (pick < 55)
        begin
            repeat ($urandom_range(1, 12)) push_byte(8'("0" + $urandom_range(0, 9)));
        end
        else if (pick < 85)
            push_text(operators[$urandom_range(0, 15)]);
        else if (pick < 94)
        begin
            repeat ($urandom_range(1, 3)) push_byte(space_char());
        end
        else if (pick < 97)
        begin
            do
            begin
                r = $urandom_range(0, 255);
                c = 8'(r);
            end
            while (!lexer_accepts(c));
            push_byte(c);
        end
        else
            push_byte(END_OF_SOURCE);
        if ($urandom_range(0, 1) == 1)
            push_byte(space_char());
    endtask

    task automatic push_fatal_tail();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 1)
        begin
            push_text("x!");
            push_byte(lead_char());
        end
        else
        begin
            do c = 8'($urandom_range(0, 255)); while (lexer_accepts(c) || c == "!");
            push_text("x");
            push_byte(c);
        end
        push_byte(8'($urandom_range(128, 255)));
        repeat (10) push_byte(8'($urandom_range(0, 255)));
        push_byte(END_OF_SOURCE);
    endtask

    initial
    begin
        int start;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_text("4294967295 2147483648!=else<");
        push_byte(END_OF_SOURCE);
        push_byte(END_OF_SOURCE);

        push_byte("q");
        repeat (LONG_IDENT_LEN - 1) push_byte(ident_char());
        push_text(" ab 7;");
        push_byte(END_OF_SOURCE);

        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
            push_token();
        push_byte(END_OF_SOURCE);

        push_fatal_tail();
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        bit   squeezed;
        int   style;
        logic [15:0] pattern;
        squeezed = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!squeezed && bytes_sent >= SQUEEZE_AT)
            begin
                squeezed = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            style   = $urandom_range(0, 3);
            pattern = 16'($urandom);
            repeat ($urandom_range(16, 96))
            begin
                case (style)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= pattern[0];
                    2: m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
                pattern = {pattern[0], pattern[15:1]};
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
